/* rtl/bytecode_int_stack_executor_assert.svh */
// ---------------------------------------------------------------------------
// assertion macros for the stack executor
// ---------------------------------------------------------------------------
`ifndef BYTECODE_INT_STACK_EXECUTOR_ASSERT_SVH
`define BYTECODE_INT_STACK_EXECUTOR_ASSERT_SVH

// same-cycle implication, disabled while reset is active
`define BISE_ASSERT_NOW(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is active
`define BISE_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/bise_pkg.sv */
// ---------------------------------------------------------------------------
// bise_pkg
// shared types and codes of the integer bytecode stack executor
// ---------------------------------------------------------------------------
package bise_pkg;

    localparam int LOCAL_IDX_W = 6;

    // instruction kinds
    localparam logic [2:0] KIND_PUSH   = 3'd0;
    localparam logic [2:0] KIND_LOAD   = 3'd1;
    localparam logic [2:0] KIND_STORE  = 3'd2;
    localparam logic [2:0] KIND_INC    = 3'd3;
    localparam logic [2:0] KIND_ADD    = 3'd4;
    localparam logic [2:0] KIND_CMPBR  = 3'd5;
    localparam logic [2:0] KIND_GOTO   = 3'd6;
    localparam logic [2:0] KIND_RETURN = 3'd7;

    // compare selectors
    localparam logic [2:0] CMP_EQ = 3'd0;
    localparam logic [2:0] CMP_NE = 3'd1;
    localparam logic [2:0] CMP_LT = 3'd2;
    localparam logic [2:0] CMP_GE = 3'd3;
    localparam logic [2:0] CMP_GT = 3'd4;
    localparam logic [2:0] CMP_LE = 3'd5;

    // error codes
    localparam logic [2:0] ERR_OK        = 3'd0;
    localparam logic [2:0] ERR_UNDERFLOW = 3'd1;
    localparam logic [2:0] ERR_OVERFLOW  = 3'd2;
    localparam logic [2:0] ERR_BAD_LOCAL = 3'd3;
    localparam logic [2:0] ERR_HALTED    = 3'd4;

    typedef struct packed {
        logic [2:0]             kind;
        logic signed [31:0]     immediate;
        logic [LOCAL_IDX_W-1:0] local_index;
        logic signed [15:0]     branch_offset;
        logic [2:0]             compare_op;
    } item_t;

    typedef struct packed {
        logic               take_jump;
        logic signed [15:0] jump_offset;
        logic               halted;
        logic               has_result;
        logic signed [31:0] result_value;
        logic [2:0]         error;
    } res_t;

    // write-back controls from the execute logic
    typedef struct packed {
        logic stk_we;
        logic loc_we;
        logic halt;
    } wb_ctl_t;

endpackage

/* rtl/bise_stack_ram.sv */
// ---------------------------------------------------------------------------
// bise_stack_ram
// operand stack storage, one write port and two registered read ports
// ---------------------------------------------------------------------------
module bise_stack_ram #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] wa,
    input  logic [31:0]   wd,
    input  logic          re,
    input  logic [AW-1:0] ra0,
    input  logic [AW-1:0] ra1,
    output logic [31:0]   rd0,
    output logic [31:0]   rd1
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
    end

    // read data holds while the execute stage is stalled
    always_ff @(posedge aclk) begin
        if (re) begin
            rd0 <= mem[ra0];
            rd1 <= mem[ra1];
        end
    end

endmodule

/* rtl/bise_local_file.sv */
// ---------------------------------------------------------------------------
// bise_local_file
// local variable slots, one write and one registered read, zero after reset
// ---------------------------------------------------------------------------
module bise_local_file #(
    parameter int LOCAL_COUNT = 64
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             we,
    input  logic [bise_pkg::LOCAL_IDX_W-1:0] wa,
    input  logic [31:0]                      wd,
    input  logic                             re,
    input  logic [bise_pkg::LOCAL_IDX_W-1:0] ra,
    output logic [31:0]                      rd
);

    // slots beyond the index range can never be reached
    localparam int IDX_SPAN = 2 ** bise_pkg::LOCAL_IDX_W;
    localparam int LOC_NUM  = (LOCAL_COUNT < IDX_SPAN) ? LOCAL_COUNT : IDX_SPAN;
    localparam int LOC_AW   = (LOC_NUM > 1) ? $clog2(LOC_NUM) : 1;

    logic [31:0]        mem [LOC_NUM];
    logic [LOC_NUM-1:0] vld_reg;
    logic [31:0]        rd_reg;
    logic               rd_vld_reg;
    logic [LOC_AW-1:0]  wa_s;
    logic [LOC_AW-1:0]  ra_s;

    assign wa_s = wa[LOC_AW-1:0];
    assign ra_s = ra[LOC_AW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (we) begin
            vld_reg[wa_s] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa_s] <= wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_reg     <= mem[ra_s];
            rd_vld_reg <= vld_reg[ra_s];
        end
    end

    // a slot never written since reset reads as zero
    assign rd = rd_vld_reg ? rd_reg : 32'd0;

endmodule

/* rtl/bise_exec.sv */
// ---------------------------------------------------------------------------
// bise_exec
// execute logic: checks, arithmetic, compare and next state for one request
// ---------------------------------------------------------------------------
module bise_exec #(
    parameter int STACK_DEPTH = 32,
    parameter int LOCAL_COUNT = 64,
    parameter int CNT_W       = 6,
    parameter int SAW         = 5
) (
    input  bise_pkg::item_t    item,
    input  logic [CNT_W-1:0]   cnt,
    input  logic               halt,
    input  logic [31:0]        top,
    input  logic [31:0]        sec,
    input  logic [31:0]        loc_val,
    output bise_pkg::res_t     res,
    output bise_pkg::wb_ctl_t  wb,
    output logic [CNT_W-1:0]   cnt_next,
    output logic [SAW-1:0]     stk_wa,
    output logic [31:0]        stk_wd,
    output logic [31:0]        loc_wd
);

    logic             uses_local;
    logic             bad_local;
    logic             cmp_true;
    logic             jump;
    logic [CNT_W-1:0] cnt_m1;
    logic [CNT_W-1:0] cnt_m2;

    assign uses_local = (item.kind == bise_pkg::KIND_LOAD) ||
                        (item.kind == bise_pkg::KIND_STORE) ||
                        (item.kind == bise_pkg::KIND_INC);
    assign bad_local  = uses_local &&
                        ({26'd0, item.local_index} >= 32'(LOCAL_COUNT));
    assign cnt_m1     = cnt - CNT_W'(1);
    assign cnt_m2     = cnt - CNT_W'(2);

    // val1 is the entry below the top, val2 the top
    always_comb begin
        unique case (item.compare_op)
            bise_pkg::CMP_EQ: cmp_true = (sec == top);
            bise_pkg::CMP_NE: cmp_true = (sec != top);
            bise_pkg::CMP_LT: cmp_true = ($signed(sec) < $signed(top));
            bise_pkg::CMP_GE: cmp_true = !($signed(sec) < $signed(top));
            bise_pkg::CMP_GT: cmp_true = ($signed(top) < $signed(sec));
            bise_pkg::CMP_LE: cmp_true = !($signed(top) < $signed(sec));
            default:          cmp_true = 1'b0;
        endcase
    end

    always_comb begin
        jump             = 1'b0;
        res              = '0;
        res.error        = bise_pkg::ERR_OK;
        wb.stk_we        = 1'b0;
        wb.loc_we        = 1'b0;
        wb.halt          = halt;
        cnt_next         = cnt;
        stk_wa           = cnt[SAW-1:0];
        stk_wd           = item.immediate;
        loc_wd           = top;
        priority if (halt) begin
            res.error = bise_pkg::ERR_HALTED;
        end else if (bad_local) begin
            res.error = bise_pkg::ERR_BAD_LOCAL;
        end else begin
            unique case (item.kind)
                bise_pkg::KIND_PUSH, bise_pkg::KIND_LOAD: begin
                    if (cnt >= CNT_W'(STACK_DEPTH)) begin
                        res.error = bise_pkg::ERR_OVERFLOW;
                    end else begin
                        wb.stk_we = 1'b1;
                        stk_wd    = (item.kind == bise_pkg::KIND_PUSH) ?
                                    item.immediate : loc_val;
                        cnt_next  = cnt + CNT_W'(1);
                    end
                end
                bise_pkg::KIND_STORE: begin
                    if (cnt == '0) begin
                        res.error = bise_pkg::ERR_UNDERFLOW;
                    end else begin
                        wb.loc_we = 1'b1;
                        cnt_next  = cnt_m1;
                    end
                end
                bise_pkg::KIND_INC: begin
                    wb.loc_we = 1'b1;
                    loc_wd    = loc_val + item.immediate;
                end
                bise_pkg::KIND_ADD: begin
                    if (cnt < CNT_W'(2)) begin
                        res.error = bise_pkg::ERR_UNDERFLOW;
                    end else begin
                        wb.stk_we = 1'b1;
                        stk_wa    = cnt_m2[SAW-1:0];
                        stk_wd    = sec + top;
                        cnt_next  = cnt_m1;
                    end
                end
                bise_pkg::KIND_CMPBR: begin
                    if (cnt < CNT_W'(2)) begin
                        res.error = bise_pkg::ERR_UNDERFLOW;
                    end else begin
                        cnt_next = cnt_m2;
                        jump     = cmp_true;
                    end
                end
                bise_pkg::KIND_GOTO: begin
                    jump = 1'b1;
                end
                bise_pkg::KIND_RETURN: begin
                    wb.halt = 1'b1;
                    if (cnt != '0) begin
                        cnt_next         = cnt_m1;
                        res.has_result   = 1'b1;
                        res.result_value = top;
                    end
                end
                default: ;
            endcase
        end
        res.take_jump   = jump;
        res.jump_offset = jump ? item.branch_offset : 16'sd0;
        res.halted      = wb.halt;
    end

endmodule

/* rtl/bytecode_int_stack_executor.sv */
// ---------------------------------------------------------------------------
// bytecode_int_stack_executor
// executes decoded integer stack-machine instructions against an operand
// stack and a local variable file, one result per request
// ---------------------------------------------------------------------------
// a request passes through the input register, then the execute register with
// the synchronous stack and local reads issued, and then the output register;
// a request issues only once the one before it has left the execute stage
// a new request is taken into the input register while another executes
// reset: stack empty, locals read as zero, not halted, no result pending
`include "bytecode_int_stack_executor_assert.svh"

module bytecode_int_stack_executor #(
    parameter int STACK_DEPTH = 32,
    parameter int LOCAL_COUNT = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // immediate[31:0], local_index[37:32], branch_offset[53:38],
    // compare_op[56:54], zero fill
    input  logic [63:0] s_tdata,
    // kind[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // take_jump[0], jump_offset[16:1], halted[17], has_result[18],
    // result_value[50:19], error[53:51], zero fill
    output logic [55:0] m_tdata
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);
    localparam int SAW   = $clog2(STACK_DEPTH);

    logic              itm_valid_reg;
    logic              exe_valid_reg;
    logic              out_valid_reg;
    bise_pkg::item_t   itm_reg;
    bise_pkg::item_t   exe_reg;
    bise_pkg::res_t    out_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              halt_reg;

    logic              s_acc;
    logic              issue;
    logic              exe_done;
    logic              out_free;
    bise_pkg::item_t   in_item;
    bise_pkg::res_t    exe_res;
    bise_pkg::wb_ctl_t wb;
    logic [CNT_W-1:0]  rd_a0;
    logic [CNT_W-1:0]  rd_a1;
    logic [SAW-1:0]    stk_wa;
    logic [31:0]       stk_wd;
    logic [31:0]       loc_wd;
    logic [31:0]       top;
    logic [31:0]       sec;
    logic [31:0]       loc_val;

    assign in_item.kind          = s_tuser;
    assign in_item.immediate     = s_tdata[31:0];
    assign in_item.local_index   = s_tdata[37:32];
    assign in_item.branch_offset = s_tdata[53:38];
    assign in_item.compare_op    = s_tdata[56:54];

    // reads are issued only with the execute stage empty, so they see
    // every earlier write-back
    assign out_free = !out_valid_reg || m_tready;
    assign exe_done = exe_valid_reg && out_free;
    assign issue    = itm_valid_reg && !exe_valid_reg;
    assign s_tready = !itm_valid_reg || issue;
    assign s_acc    = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            itm_valid_reg <= 1'b0;
            exe_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
            halt_reg      <= 1'b0;
        end else begin
            if (s_acc) begin
                itm_valid_reg <= 1'b1;
            end else if (issue) begin
                itm_valid_reg <= 1'b0;
            end
            if (issue) begin
                exe_valid_reg <= 1'b1;
            end else if (exe_done) begin
                exe_valid_reg <= 1'b0;
            end
            if (exe_done) begin
                out_valid_reg <= 1'b1;
                cnt_reg       <= cnt_next;
                halt_reg      <= wb.halt;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            itm_reg <= in_item;
        end
        if (issue) begin
            exe_reg <= itm_reg;
        end
        if (exe_done) begin
            out_reg <= exe_res;
        end
    end

    assign rd_a0 = cnt_reg - CNT_W'(1);
    assign rd_a1 = cnt_reg - CNT_W'(2);

    bise_stack_ram #(
        .DEPTH (STACK_DEPTH),
        .AW    (SAW)
    ) u_stack (
        .aclk (aclk),
        .we   (exe_done && wb.stk_we),
        .wa   (stk_wa),
        .wd   (stk_wd),
        .re   (issue),
        .ra0  (rd_a0[SAW-1:0]),
        .ra1  (rd_a1[SAW-1:0]),
        .rd0  (top),
        .rd1  (sec)
    );

    bise_local_file #(
        .LOCAL_COUNT (LOCAL_COUNT)
    ) u_locals (
        .aclk    (aclk),
        .aresetn (aresetn),
        .we      (exe_done && wb.loc_we),
        .wa      (exe_reg.local_index),
        .wd      (loc_wd),
        .re      (issue),
        .ra      (itm_reg.local_index),
        .rd      (loc_val)
    );

    bise_exec #(
        .STACK_DEPTH (STACK_DEPTH),
        .LOCAL_COUNT (LOCAL_COUNT),
        .CNT_W       (CNT_W),
        .SAW         (SAW)
    ) u_exec (
        .item     (exe_reg),
        .cnt      (cnt_reg),
        .halt     (halt_reg),
        .top      (top),
        .sec      (sec),
        .loc_val  (loc_val),
        .res      (exe_res),
        .wb       (wb),
        .cnt_next (cnt_next),
        .stk_wa   (stk_wa),
        .stk_wd   (stk_wd),
        .loc_wd   (loc_wd)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_reg.error, out_reg.result_value, out_reg.has_result,
                       out_reg.halted, out_reg.jump_offset, out_reg.take_jump};

    `BISE_ASSERT_NOW(a_cnt_in_range, aclk, aresetn, 1'b1,
        cnt_reg <= CNT_W'(STACK_DEPTH), "stack count above depth")
    `BISE_ASSERT_NEXT(a_halt_sticky, aclk, aresetn, halt_reg,
        halt_reg, "halt flag cleared without reset")
    `BISE_ASSERT_NEXT(a_done_shows, aclk, aresetn, exe_done,
        m_tvalid, "executed request produced no result")
    `BISE_ASSERT_NOW(a_result_halts, aclk, aresetn, m_tvalid && out_reg.has_result,
        out_reg.halted && (out_reg.error == bise_pkg::ERR_OK) && !out_reg.take_jump,
        "returned value without clean halt")

endmodule
